// ===== rtl/core/mlr_pkg.sv =====
package mlr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int WIDTH_BITS     = 7;
    localparam int COLOR_BITS     = 24;
    localparam int ADDR_BITS      = 14;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

    typedef enum logic [1:0] {
        OCT_SHALLOW_RISE = 2'd0,
        OCT_SHALLOW_FALL = 2'd1,
        OCT_STEEP_RISE   = 2'd2,
        OCT_STEEP_FALL   = 2'd3
    } octant_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DRAW
    } state_t;

    // Line classification handed from the setup logic to the stepper.
    typedef struct packed {
        octant_t octant;
        logic    vert;
    } line_mode_t;

endpackage

// ===== rtl/core/mlr_setup.sv =====
module mlr_setup #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
    parameter int DEC_BITS   = COORD_BITS + 4
) (
    input  logic [COORD_BITS-1:0]      sx,
    input  logic [COORD_BITS-1:0]      sy,
    input  logic [COORD_BITS-1:0]      ex,
    input  logic [COORD_BITS-1:0]      ey,
    output logic [COORD_BITS-1:0]      start_x,
    output logic [COORD_BITS-1:0]      start_y,
    output logic [COORD_BITS-1:0]      count,
    output logic signed [DEC_BITS-1:0] d_init,
    output logic signed [DEC_BITS-1:0] inc_a,
    output logic signed [DEC_BITS-1:0] inc_b,
    output mlr_pkg::line_mode_t        mode
);
    import mlr_pkg::*;

    logic                         swap;
    logic [COORD_BITS-1:0]        x1;
    logic [COORD_BITS-1:0]        y1;
    logic [COORD_BITS-1:0]        x2;
    logic [COORD_BITS-1:0]        y2;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        abs_up;
    logic signed [COORD_BITS:0]   up;
    logic signed [COORD_BITS:0]   neg_up;
    logic signed [DEC_BITS-1:0]   dxe;
    logic signed [DEC_BITS-1:0]   upe;
    logic                         vert;
    octant_t                      oct;

    always_comb
    begin
        swap   = (sx > ex);
        x1     = swap ? ex : sx;
        y1     = swap ? ey : sy;
        x2     = swap ? sx : ex;
        y2     = swap ? sy : ey;
        dx     = x2 - x1;
        up     = $signed({1'b0, y1}) - $signed({1'b0, y2});
        neg_up = -up;
        abs_up = up[COORD_BITS] ? neg_up[COORD_BITS-1:0] : up[COORD_BITS-1:0];
        vert   = (dx == '0);
        dxe    = $signed({{(DEC_BITS-COORD_BITS){1'b0}}, dx});
        upe    = $signed({{(DEC_BITS-COORD_BITS-1){up[COORD_BITS]}}, up});
    end

    always_comb
    begin
        priority if (vert)
            oct = OCT_STEEP_FALL;
        else if (!up[COORD_BITS] && (abs_up <= dx))
            oct = OCT_SHALLOW_RISE;
        else if (up[COORD_BITS] && (abs_up <= dx))
            oct = OCT_SHALLOW_FALL;
        else if (!up[COORD_BITS])
            oct = OCT_STEEP_RISE;
        else
            oct = OCT_STEEP_FALL;
    end

    // The decision values below are the midpoint sums evaluated at the first
    // pixel; the cross terms cancel because the line passes through both ends.
    always_comb
    begin
        start_x = x1;
        start_y = y1;
        count   = abs_up;
        unique case (oct)
            OCT_SHALLOW_RISE:
            begin
                count  = dx;
                d_init = (upe <<< 1) - dxe;
                inc_a  = upe <<< 1;
                inc_b  = (upe <<< 1) - (dxe <<< 1);
            end
            OCT_SHALLOW_FALL:
            begin
                count  = dx;
                d_init = (upe <<< 1) + dxe;
                inc_a  = upe <<< 1;
                inc_b  = (upe <<< 1) + (dxe <<< 1);
            end
            OCT_STEEP_RISE:
            begin
                start_x = x2;
                start_y = y2;
                d_init  = (dxe <<< 1) - upe;
                inc_a   = dxe <<< 1;
                inc_b   = (dxe <<< 1) - (upe <<< 1);
            end
            OCT_STEEP_FALL:
            begin
                d_init = upe + (dxe <<< 1);
                inc_a  = dxe <<< 1;
                inc_b  = (dxe <<< 1) + (upe <<< 1);
            end
            default:
            begin
                d_init = '0;
                inc_a  = '0;
                inc_b  = '0;
            end
        endcase
        // A vertical line always walks from the smaller row downward.
        if (vert && !up[COORD_BITS])
            start_y = y2;
    end

    assign mode.octant = oct;
    assign mode.vert   = vert;

endmodule

// ===== rtl/core/mlr_stepper.sv =====
module mlr_stepper #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
    parameter int DEC_BITS   = COORD_BITS + 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       step,
    input  logic [COORD_BITS-1:0]      start_x,
    input  logic [COORD_BITS-1:0]      start_y,
    input  logic [COORD_BITS-1:0]      count,
    input  logic signed [DEC_BITS-1:0] d_init,
    input  logic signed [DEC_BITS-1:0] inc_a,
    input  logic signed [DEC_BITS-1:0] inc_b,
    input  mlr_pkg::line_mode_t        mode,
    output logic [COORD_BITS-1:0]      cur_x,
    output logic [COORD_BITS-1:0]      cur_y,
    output logic                       last
);
    import mlr_pkg::*;

    logic [COORD_BITS-1:0]      x_reg,     x_next;
    logic [COORD_BITS-1:0]      y_reg,     y_next;
    logic [COORD_BITS-1:0]      cnt_reg,   cnt_next;
    logic signed [DEC_BITS-1:0] d_reg,     d_next;
    logic signed [DEC_BITS-1:0] inc_a_reg, inc_a_next;
    logic signed [DEC_BITS-1:0] inc_b_reg, inc_b_next;
    line_mode_t                 mode_reg,  mode_next;
    logic                       take;
    logic                       major_x;
    logic                       minor_neg;
    logic signed [DEC_BITS-1:0] d_sum;

    always_comb
    begin
        unique case (mode_reg.octant)
            OCT_SHALLOW_RISE:
            begin
                take      = (d_reg >= 0);
                major_x   = 1'b1;
                minor_neg = 1'b1;
            end
            OCT_SHALLOW_FALL:
            begin
                take      = (d_reg <= 0);
                major_x   = 1'b1;
                minor_neg = 1'b0;
            end
            OCT_STEEP_RISE:
            begin
                take      = (d_reg >= 0);
                major_x   = 1'b0;
                minor_neg = 1'b1;
            end
            OCT_STEEP_FALL:
            begin
                take      = (d_reg >= 0);
                major_x   = 1'b0;
                minor_neg = 1'b0;
            end
            default:
            begin
                take      = 1'b0;
                major_x   = 1'b0;
                minor_neg = 1'b0;
            end
        endcase
        if (mode_reg.vert)
            take = 1'b0;
    end

    // The one adder that carries the decision value from pixel to pixel.
    assign d_sum = d_reg + (take ? inc_b_reg : inc_a_reg);

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        inc_a_next = inc_a_reg;
        inc_b_next = inc_b_reg;
        mode_next  = mode_reg;
        if (load)
        begin
            x_next     = start_x;
            y_next     = start_y;
            cnt_next   = count;
            d_next     = d_init;
            inc_a_next = inc_a;
            inc_b_next = inc_b;
            mode_next  = mode;
        end
        else if (step)
        begin
            d_next   = d_sum;
            cnt_next = cnt_reg - 1'b1;
            if (major_x)
            begin
                x_next = x_reg + 1'b1;
                if (take)
                    y_next = minor_neg ? y_reg - 1'b1 : y_reg + 1'b1;
            end
            else
            begin
                y_next = y_reg + 1'b1;
                if (take)
                    x_next = minor_neg ? x_reg - 1'b1 : x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            cnt_reg   <= '0;
            mode_reg  <= '{octant: OCT_SHALLOW_RISE, vert: 1'b0};
        end
        else
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        inc_a_reg <= inc_a_next;
        inc_b_reg <= inc_b_next;
    end

    assign cur_x = x_reg;
    assign cur_y = y_reg;
    assign last  = (cnt_reg == '0);

endmodule

// ===== rtl/core/midpoint_line_rasterizer_core.sv =====
// Midpoint line rasterizer.
// The command channel (cmd_valid / cmd_stall) carries one line request: two
// endpoints and a packed color. The pixel channel (pix_valid / pix_stall)
// returns every pixel of that line in drawing order with its frame buffer
// byte address 3*(image_width*y + x), the color, and last_pixel on the end.
// cfg_write_en / cfg_write_data set image_width; write it only while idle.
// After the request is taken, the set-up logic decodes it and loads the
// stepper, and the first pixel is then loaded into the pixel register.
// Throughput: one pixel per cycle while pix_stall is low, set by the single
// decision adder in the stepper. cmd_stall stays high from the request until
// the last pixel has been loaded into the output register.
// When the receiver raises pix_stall the held pixel does not change and the
// stepper pauses until the pixel is taken.
// Reset clears both channels and returns image_width to 64.
module midpoint_line_rasterizer_core #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mlr_pkg::WIDTH_BITS-1:0] cfg_write_data,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [COORD_BITS-1:0]          start_x,
    input  logic [COORD_BITS-1:0]          start_y,
    input  logic [COORD_BITS-1:0]          end_x,
    input  logic [COORD_BITS-1:0]          end_y,
    input  logic [mlr_pkg::COLOR_BITS-1:0] line_color,
    output logic                           pix_valid,
    input  logic                           pix_stall,
    output logic [COORD_BITS-1:0]          pixel_x,
    output logic [COORD_BITS-1:0]          pixel_y,
    output logic [mlr_pkg::ADDR_BITS-1:0]  byte_addr,
    output logic [mlr_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           last_pixel
);
    import mlr_pkg::*;

    localparam int DEC_BITS  = COORD_BITS + 4;
    localparam int PROD_BITS = WIDTH_BITS + COORD_BITS + 3;
    localparam int CALC_BITS = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

    state_t                  state_reg, state_next;
    logic [WIDTH_BITS-1:0]   width_reg;
    logic [COORD_BITS-1:0]   sx_reg, sy_reg, ex_reg, ey_reg;
    logic [COLOR_BITS-1:0]   color_reg;

    logic                    pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0]   px_reg, py_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [COLOR_BITS-1:0]   pcolor_reg;
    logic                    plast_reg;

    logic                    cmd_accept;
    logic                    emit;
    logic                    load;

    logic [COORD_BITS-1:0]      su_start_x, su_start_y, su_count;
    logic signed [DEC_BITS-1:0] su_d_init, su_inc_a, su_inc_b;
    line_mode_t                 su_mode;
    logic [COORD_BITS-1:0]      cur_x, cur_y;
    logic                       step_last;
    logic [CALC_BITS-1:0]       lin_idx;
    logic [CALC_BITS-1:0]       addr_full;

    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = ST_SETUP;
            ST_SETUP:
                state_next = ST_DRAW;
            ST_DRAW:
                if (emit && step_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        load      = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                cmd_stall = 1'b0;
            ST_SETUP:
                load = 1'b1;
            ST_DRAW:
                emit = !pix_valid_reg || !pix_stall;
            default:
                cmd_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (emit)
            pix_valid_next = 1'b1;
        else if (!pix_stall)
            pix_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_RESET;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pix_valid_reg <= pix_valid_next;
            if (cfg_write_en)
                width_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            sx_reg    <= start_x;
            sy_reg    <= start_y;
            ex_reg    <= end_x;
            ey_reg    <= end_y;
            color_reg <= line_color;
        end
        if (emit)
        begin
            px_reg     <= cur_x;
            py_reg     <= cur_y;
            addr_reg   <= addr_full[ADDR_BITS-1:0];
            pcolor_reg <= color_reg;
            plast_reg  <= step_last;
        end
    end

    mlr_setup #(
        .COORD_BITS (COORD_BITS),
        .DEC_BITS   (DEC_BITS)
    ) u_setup (
        .sx      (sx_reg),
        .sy      (sy_reg),
        .ex      (ex_reg),
        .ey      (ey_reg),
        .start_x (su_start_x),
        .start_y (su_start_y),
        .count   (su_count),
        .d_init  (su_d_init),
        .inc_a   (su_inc_a),
        .inc_b   (su_inc_b),
        .mode    (su_mode)
    );

    mlr_stepper #(
        .COORD_BITS (COORD_BITS),
        .DEC_BITS   (DEC_BITS)
    ) u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .step    (emit),
        .start_x (su_start_x),
        .start_y (su_start_y),
        .count   (su_count),
        .d_init  (su_d_init),
        .inc_a   (su_inc_a),
        .inc_b   (su_inc_b),
        .mode    (su_mode),
        .cur_x   (cur_x),
        .cur_y   (cur_y),
        .last    (step_last)
    );

    // Row-major pixel index, then times three as index + 2*index.
    assign lin_idx   = CALC_BITS'(width_reg) * CALC_BITS'(cur_y) + CALC_BITS'(cur_x);
    assign addr_full = lin_idx + (lin_idx << 1);

    assign pix_valid   = pix_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign byte_addr   = addr_reg;
    assign pixel_color = pcolor_reg;
    assign last_pixel  = plast_reg;

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> state_reg == ST_SETUP)
        else $error("accepted request did not enter set-up");

    a_setup_draw: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETUP |=> state_reg == ST_DRAW && !pix_valid_reg || state_reg == ST_DRAW)
        else $error("set-up did not lead to drawing");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && step_last |=> state_reg == ST_IDLE && pix_valid_reg && plast_reg)
        else $error("final pixel did not end the line");

    a_no_early_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAW && !(emit && step_last) |=> cmd_stall)
        else $error("request taken while a line is still being drawn");

endmodule
